### sv/assert_macros.svh
// Assertion macros shared by the sieve counter RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/psc_pkg.sv
// Shared constants, types and helper functions of the prime sieve counter.
// Used by the controller, the datapath and the top level.
package psc_pkg;

    localparam int unsigned MAX_LIMIT = 65535;
    localparam int unsigned DEPTH     = MAX_LIMIT + 1;
    localparam int unsigned ADDR_W    = $clog2(DEPTH);
    localparam int unsigned LIMIT_W   = 16;
    localparam int unsigned COUNT_W   = 13;
    localparam int unsigned OUT_TDATA_W = 16;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FILL = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_CHK  = 6'b001000,
        ST_MARK = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // load limit, clear counter, reset address and index
        logic fill;      // write the initial mark at the address counter
        logic rd;        // read the candidate bit at the index, square the index
        logic count_inc; // the candidate read back is a prime
        logic mark_init; // start clearing multiples at the square
        logic mark;      // clear one multiple and step by the index
        logic next_i;    // advance the scan index
        logic finish;    // load the count into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last; // the address counter is at the limit
        logic i_over;    // the scan index is past the limit
        logic bit_set;   // registered candidate bit
        logic sq_ok;     // the square of the index is within the limit
        logic mark_last; // the next multiple is past the limit
        logic out_free;  // the output register can take a result
    } sts_t;

    function automatic logic [ADDR_W-1:0] sat_limit(input logic [LIMIT_W-1:0] l);
        logic [ADDR_W-1:0] r;
        if (32'(l) > MAX_LIMIT)
            r = ADDR_W'(MAX_LIMIT);
        else
            r = ADDR_W'(l);
        return r;
    endfunction

endpackage

### sv/psc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module psc_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/psc_ctrl.sv
// Controller state machine of the prime sieve counter.
// Depends on psc_pkg for the state, command and status types.
module psc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  psc_pkg::sts_t sts,
    output psc_pkg::cmd_t cmd
);

    psc_pkg::state_t state_reg;
    psc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = psc_pkg::ST_FILL;
                end
            end
            psc_pkg::ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = psc_pkg::ST_SCAN;
                end
            end
            psc_pkg::ST_SCAN:
            begin
                if (sts.i_over)
                begin
                    state_next = psc_pkg::ST_DONE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = psc_pkg::ST_CHK;
                end
            end
            psc_pkg::ST_CHK:
            begin
                cmd.count_inc = sts.bit_set;
                if (sts.bit_set && sts.sq_ok)
                begin
                    cmd.mark_init = 1'b1;
                    state_next    = psc_pkg::ST_MARK;
                end
                else
                begin
                    cmd.next_i = 1'b1;
                    state_next = psc_pkg::ST_SCAN;
                end
            end
            psc_pkg::ST_MARK:
            begin
                cmd.mark = 1'b1;
                if (sts.mark_last)
                begin
                    cmd.next_i = 1'b1;
                    state_next = psc_pkg::ST_SCAN;
                end
            end
            psc_pkg::ST_DONE:
            begin
                // Hold the count until the previous result has left.
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = psc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/psc_datapath.sv
// Datapath of the prime sieve counter: candidate bit store, counters and result register.
// Depends on psc_pkg and psc_ram.
module psc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  psc_pkg::cmd_t                     cmd,
    output psc_pkg::sts_t                     sts,
    input  logic [psc_pkg::LIMIT_W-1:0]       limit,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [psc_pkg::COUNT_W-1:0]       prime_count
);

    localparam int unsigned AW = psc_pkg::ADDR_W;

    logic [AW-1:0]                 lim_reg;
    logic [AW:0]                   j_reg;
    logic [AW:0]                   i_reg;
    logic [2*AW-1:0]               sq_reg;
    logic [psc_pkg::COUNT_W-1:0]   count_reg;
    logic [psc_pkg::COUNT_W-1:0]   result_reg;
    logic                          out_valid_reg;
    logic [AW+1:0]                 j_step;
    logic                          ram_we;
    logic                          ram_wdata;
    logic                          ram_rdata;

    // Entries 0 and 1 get a cleared mark during the fill, all others a set one.
    assign ram_we    = cmd.fill || cmd.mark;
    assign ram_wdata = cmd.fill && (j_reg >= (AW+1)'(2));

    psc_ram #(
        .WIDTH (1),
        .DEPTH (psc_pkg::DEPTH)
    ) u_bits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (j_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (i_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign j_step = (AW+2)'(j_reg) + (AW+2)'(i_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lim_reg <= psc_pkg::sat_limit(limit);
        end
        if (cmd.start)
        begin
            j_reg <= '0;
        end
        else if (cmd.fill)
        begin
            j_reg <= j_reg + (AW+1)'(1);
        end
        else if (cmd.mark_init)
        begin
            j_reg <= sq_reg[AW:0];
        end
        else if (cmd.mark)
        begin
            j_reg <= j_step[AW:0];
        end
        if (cmd.start)
        begin
            i_reg <= (AW+1)'(2);
        end
        else if (cmd.next_i)
        begin
            i_reg <= i_reg + (AW+1)'(1);
        end
        if (cmd.rd)
        begin
            sq_reg <= (2*AW)'(i_reg[AW-1:0]) * (2*AW)'(i_reg[AW-1:0]);
        end
        if (cmd.start)
        begin
            count_reg <= '0;
        end
        else if (cmd.count_inc)
        begin
            count_reg <= count_reg + psc_pkg::COUNT_W'(1);
        end
        if (cmd.finish)
        begin
            result_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.fill_last = (j_reg == (AW+1)'(lim_reg));
    assign sts.i_over    = (i_reg > (AW+1)'(lim_reg));
    assign sts.bit_set   = ram_rdata;
    assign sts.sq_ok     = (sq_reg <= (2*AW)'(lim_reg));
    assign sts.mark_last = (j_step > (AW+2)'(lim_reg));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign prime_count = result_reg;

endmodule

### sv/prime_sieve_counter.sv
// Prime sieve counter: counts the primes up to a limit with a Sieve of Eratosthenes.
// Usage:
//   The slave stream takes one limit per transaction; the master stream returns
//   the number of primes less than or equal to that limit.
//   Limits above the store size saturate to the highest store index.
//   A job fills limit+1 bit entries one per cycle, then scans each index with a store
//   read and its check, and clears each multiple of a prime whose square is within
//   the limit, about 124000 multiples at the full range.
//   One job runs at a time: s_axis_tready is high only while the block is idle.
//   The result sits in an output register, so a new limit is taken while the
//   previous count still waits; a job that finishes before that count is taken
//   waits for it.
//   Reset clears the controller and the output valid flag; the bit store keeps
//   its contents, which every job overwrites before reading.
// Depends on psc_pkg, psc_ctrl, psc_datapath, psc_ram and assert_macros.svh.
`include "assert_macros.svh"
module prime_sieve_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] limit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [12:0] prime_count, [15:13] zero
);

    psc_pkg::cmd_t                   cmd;
    psc_pkg::sts_t                   sts;
    logic [psc_pkg::COUNT_W-1:0]     prime_count;

    psc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .limit       (s_axis_tdata[psc_pkg::LIMIT_W-1:0]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .prime_count (prime_count)
    );

    assign m_axis_tdata = psc_pkg::OUT_TDATA_W'(prime_count);

    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.finish, !m_axis_tvalid || m_axis_tready)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.finish, m_axis_tvalid)
    `ASSERT_IMPLIES(a_one_writer, clk, rst_n, cmd.fill, !cmd.mark && !cmd.rd)

endmodule

### sim/tb_prime_sieve_counter.sv
// Self-checking testbench for prime_sieve_counter: limits go in on the slave stream and
// each returned prime count is checked against a software sieve kept in a scoreboard.
// Depends on psc_pkg and the prime_sieve_counter RTL.
module tb_prime_sieve_counter;

    localparam int unsigned IDLE_LIMIT  = 2000000;
    localparam int unsigned DRAIN       = 64;
    localparam int unsigned RANDOM_JOBS = 75;
    localparam int unsigned CALM_JOBS   = 15;

    class prime_tally_board;
        logic [psc_pkg::COUNT_W-1:0] expected_counts[$];
        bit                          sieve_bits[0:psc_pkg::MAX_LIMIT];
        int unsigned                 errors;

        function new();
            errors = 0;
        endfunction

        function logic [psc_pkg::COUNT_W-1:0] sieve_count(
            input logic [psc_pkg::LIMIT_W-1:0] lim_in);
            int unsigned lim;
            int unsigned i;
            int unsigned j;
            int unsigned total;
            lim = 32'(lim_in);
            if (lim > psc_pkg::MAX_LIMIT)
                lim = psc_pkg::MAX_LIMIT;
            total = 0;
            for (i = 0; i <= lim; i++)
                sieve_bits[i] = 1'b1;
            sieve_bits[0] = 1'b0;
            sieve_bits[1] = 1'b0;
            for (i = 2; i <= lim; i++)
            begin
                if (sieve_bits[i])
                begin
                    total++;
                    if (i * i <= lim)
                    begin
                        for (j = i * i; j <= lim; j += i)
                            sieve_bits[j] = 1'b0;
                    end
                end
            end
            return psc_pkg::COUNT_W'(total);
        endfunction

        function void note_limit(input logic [psc_pkg::LIMIT_W-1:0] lim);
            expected_counts.push_back(sieve_count(lim));
        endfunction

        function void check_count(input logic [15:0] data);
            logic [psc_pkg::COUNT_W-1:0] want;
            logic [psc_pkg::COUNT_W-1:0] got;
            got = data[psc_pkg::COUNT_W-1:0];
            if (expected_counts.size() == 0)
            begin
                $error("prime_count: no count pending, actual %0d", got);
                errors++;
            end
            else
            begin
                want = expected_counts.pop_front();
                if (got !== want)
                begin
                    $error("prime_count mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_counts.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] limit
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [12:0] prime_count, [15:13] zero

    prime_tally_board board;
    bit               calm;

    prime_sieve_counter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Presents one limit, optionally after an idle burst, and holds it until the
    // transaction completes.
    task automatic send_limit(input logic [psc_pkg::LIMIT_W-1:0] lim, input bit allow_gap);
        int unsigned gap;
        if (allow_gap && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= lim;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_limit(lim);
    endtask

    // Most jobs stay small since a job fills and scans every number up to its limit.
    function automatic logic [psc_pkg::LIMIT_W-1:0] pick_limit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return psc_pkg::LIMIT_W'($urandom_range(0, 255));
        else if (r < 95)
            return psc_pkg::LIMIT_W'($urandom_range(256, 2047));
        else
            return psc_pkg::LIMIT_W'($urandom_range(2048, 8191));
    endfunction

    // Result side: check each completed transaction, then choose the next tready.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check_count(m_axis_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no transaction completes for too long.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [psc_pkg::LIMIT_W-1:0] directed[$];
        int unsigned                 k;
        board = new();
        calm  = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Limits below two, prime boundaries, square boundaries, bit patterns, the full
        // range, and small jobs after it that leave stale entries above their limit.
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd8, 16'd9, 16'd10,
                     16'd24, 16'd25, 16'd48, 16'd49, 16'd121, 16'd127, 16'd128,
                     16'd255, 16'd1023, 16'd1024, 16'd2047, 16'hFFFF, 16'd3, 16'd30,
                     16'd1, 16'd169};
        for (k = 0; k < 32'(directed.size()); k++)
            send_limit(directed[k], 1'b1);

        for (k = 0; k < RANDOM_JOBS; k++)
        begin
            if (k == RANDOM_JOBS - CALM_JOBS)
                calm = 1'b1;
            send_limit(pick_limit(), !calm);
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/psc_pkg.sv
sv/psc_ram.sv
sv/psc_ctrl.sv
sv/psc_datapath.sv
sv/prime_sieve_counter.sv
sim/tb_prime_sieve_counter.sv
